>>> rtl/udp_probe_frame_builder_defines.svh
// Assertion macros for the UDP probe frame builder checker.
`ifndef UDP_PROBE_FRAME_BUILDER_DEFINES_SVH
`define UDP_PROBE_FRAME_BUILDER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define UPFB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("upfb assertion failed");

// Property checked on every clock edge, reset included.
`define UPFB_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("upfb assertion failed");

`endif

>>> rtl/upfb_pkg.sv
// Types, constants and the frame byte map of the UDP probe frame builder.
`timescale 1ns / 1ps

package upfb_pkg;

    localparam int FRAME_BYTES = 47;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MAC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_IP  = 1'b1;

    // Sum of the fixed IPv4 header words: 0x4500 + 33 + 42 + 0 + 0xff11
    localparam logic [16:0] CSUM_CONST = 17'h1445c;

    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] PROBE_SRC_PORT = 16'd4242;

    typedef struct packed {
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
    } upfb_in_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } upfb_out_t;

    typedef struct packed {
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
        logic [15:0] csum;
    } upfb_hdr_t;

    function automatic logic [7:0] frame_byte_at(
        input logic [IDX_W-1:0] idx,
        input logic [47:0]      mac,
        input logic [31:0]      sip,
        input upfb_hdr_t        hdr
    );
        logic [7:0] b;
        b = 8'h00;
        unique case (idx)
            6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5: b = 8'hff;
            6'd6:  b = mac[47:40];
            6'd7:  b = mac[39:32];
            6'd8:  b = mac[31:24];
            6'd9:  b = mac[23:16];
            6'd10: b = mac[15:8];
            6'd11: b = mac[7:0];
            6'd12: b = ETH_TYPE_IPV4[15:8];
            6'd13: b = ETH_TYPE_IPV4[7:0];
            6'd14: b = 8'h45;
            6'd17: b = 8'd33;
            6'd19: b = 8'd42;
            6'd22: b = 8'd255;
            6'd23: b = 8'd17;
            6'd24: b = hdr.csum[15:8];
            6'd25: b = hdr.csum[7:0];
            6'd26: b = sip[31:24];
            6'd27: b = sip[23:16];
            6'd28: b = sip[15:8];
            6'd29: b = sip[7:0];
            6'd30: b = hdr.dest_ip[31:24];
            6'd31: b = hdr.dest_ip[23:16];
            6'd32: b = hdr.dest_ip[15:8];
            6'd33: b = hdr.dest_ip[7:0];
            6'd34: b = PROBE_SRC_PORT[15:8];
            6'd35: b = PROBE_SRC_PORT[7:0];
            6'd36: b = hdr.dest_port[15:8];
            6'd37: b = hdr.dest_port[7:0];
            6'd39: b = 8'd13;
            6'd42: b = 8'h41;
            6'd43: b = 8'h42;
            6'd44: b = 8'h43;
            6'd45: b = 8'h44;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/upfb_csum.sv
// Three-stage IPv4 header checksum pipeline.
`timescale 1ns / 1ps

module upfb_csum (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [31:0]       source_ip,
    input  logic              in_valid,
    output logic              in_ready,
    input  upfb_pkg::upfb_in_t  in_data,
    output logic              hdr_valid,
    input  logic              hdr_ready,
    output upfb_pkg::upfb_hdr_t hdr
);
    import upfb_pkg::*;

    logic        v1_reg, v2_reg, v3_reg;
    logic        rdy1, rdy2, rdy3;
    upfb_in_t    d1_reg, d2_reg;
    upfb_hdr_t   d3_reg;
    logic [17:0] s1_reg;
    logic [16:0] f2_reg;
    logic [18:0] s2;
    logic [16:0] f2_next;
    logic [15:0] csum_next;

    assign rdy3     = !v3_reg || hdr_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Add the fixed words, then fold the carries once
    assign s2      = {1'b0, s1_reg} + {2'b00, CSUM_CONST};
    assign f2_next = {1'b0, s2[15:0]} + {14'b0, s2[18:16]};
    // Second fold cannot carry out again
    assign csum_next = ~(f2_reg[15:0] + {15'b0, f2_reg[16]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            d1_reg <= in_data;
            s1_reg <= {2'b00, source_ip[31:16]} + {2'b00, source_ip[15:0]}
                    + {2'b00, in_data.dest_ip[31:16]} + {2'b00, in_data.dest_ip[15:0]};
        end
        if (rdy2 && v1_reg) begin
            d2_reg <= d1_reg;
            f2_reg <= f2_next;
        end
        if (rdy3 && v2_reg) begin
            d3_reg.dest_ip   <= d2_reg.dest_ip;
            d3_reg.dest_port <= d2_reg.dest_port;
            d3_reg.csum      <= csum_next;
        end
    end

    assign hdr_valid = v3_reg;
    assign hdr       = d3_reg;

endmodule

>>> rtl/upfb_ser.sv
// Frame serializer: one header in, 47 bytes out through a registered output.
`timescale 1ns / 1ps

module upfb_ser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [47:0]         source_mac,
    input  logic [31:0]         source_ip,
    input  logic                hdr_valid,
    output logic                hdr_ready,
    input  upfb_pkg::upfb_hdr_t hdr,
    output logic                m_valid,
    input  logic                m_ready,
    output upfb_pkg::upfb_out_t m_data
);
    import upfb_pkg::*;

    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    upfb_hdr_t        hdr_reg, hdr_next;
    logic             m_valid_reg, m_valid_next;
    upfb_out_t        m_data_reg, m_data_next;
    logic             out_load;
    logic             last;

    assign out_load  = !m_valid_reg || m_ready;
    assign last      = (cnt_reg == LAST_IDX);
    // Take the next header in the cycle the last byte moves to the output
    assign hdr_ready = !busy_reg || (out_load && last);

    always_comb begin
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        hdr_next     = hdr_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (busy_reg && out_load) begin
            m_valid_next           = 1'b1;
            m_data_next.frame_byte = frame_byte_at(cnt_reg, source_mac, source_ip, hdr_reg);
            m_data_next.last_byte  = last;
            cnt_next               = cnt_reg + 1'b1;
            if (last) begin
                busy_next = 1'b0;
            end
        end
        if (hdr_valid && hdr_ready) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            hdr_next  = hdr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hdr_reg    <= hdr_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/udp_probe_frame_builder.sv
// UDP probe frame builder: top level with configuration registers.
`timescale 1ns / 1ps

// Each accepted request (dest_ip, dest_port) produces one 47-byte Ethernet/IPv4/UDP
// frame on m_data, one byte per word, with last_byte set on the 47th. The byte-wide
// serializer output limits the request rate: it takes a new header only as the last
// byte of the previous frame moves to the output, and with m_ready held high the
// bytes of consecutive frames follow without gaps. A request passes a
// three-stage header checksum pipeline before serialization, and further
// requests wait in that pipeline while a frame is going out. source_mac (index 0)
// and source_ip (index 1) are written through cfg_we/cfg_index/cfg_wdata and must
// only change while no frame is pending; both reset to zero.
module udp_probe_frame_builder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  upfb_pkg::upfb_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output upfb_pkg::upfb_out_t                 m_data,
    input  logic                                cfg_we,
    input  logic [upfb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [upfb_pkg::CFG_W-1:0]          cfg_wdata
);
    import upfb_pkg::*;

    logic [47:0] source_mac_reg;
    logic [31:0] source_ip_reg;
    logic        hdr_valid;
    logic        hdr_ready;
    upfb_hdr_t   hdr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_mac_reg <= '0;
            source_ip_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SOURCE_MAC: source_mac_reg <= cfg_wdata[47:0];
                REG_SOURCE_IP:  source_ip_reg  <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    upfb_csum u_csum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .source_ip (source_ip_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .hdr_valid (hdr_valid),
        .hdr_ready (hdr_ready),
        .hdr       (hdr)
    );

    upfb_ser u_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .source_mac (source_mac_reg),
        .source_ip  (source_ip_reg),
        .hdr_valid  (hdr_valid),
        .hdr_ready  (hdr_ready),
        .hdr        (hdr),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

>>> rtl/upfb_checker.sv
// Port-level checker for the UDP probe frame builder, bound to the top level.
`timescale 1ns / 1ps
`include "udp_probe_frame_builder_defines.svh"

module upfb_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input upfb_pkg::upfb_out_t             m_data
);
    import upfb_pkg::*;

    // A stalled output word holds
    `UPFB_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data))
    // A frame is never a single byte long
    `UPFB_ASSERT(a_no_double_last, m_valid && m_ready && m_data.last_byte |=> !(m_valid && m_data.last_byte))
    // A word right after the end of a frame opens with the broadcast address
    `UPFB_ASSERT(a_frame_start, m_valid && m_ready && m_data.last_byte |=> !m_valid || m_data.frame_byte == 8'hff)
    // Reset empties the output
    `UPFB_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid)

endmodule

bind udp_probe_frame_builder upfb_checker u_upfb_checker (.*);
